// ===== rtl/core/ihq_pkg.sv =====
// Shared types and codes for the indexed max-heap queue.
package ihq_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned LABEL_W = 6;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_PRESENT = 2'd3;

	typedef struct packed {
		logic               command;
		logic [LABEL_W-1:0] label;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] removed_value;
		logic [LABEL_W-1:0] removed_label;
		logic [VALUE_W-1:0] max_value;
		logic [LABEL_W-1:0] max_label;
		logic               empty_res;
	} rsp_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [LABEL_W-1:0] label;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAPRD,
		S_CHECK,
		S_RDGONE,
		S_RDLAST,
		S_UPRD,
		S_UPCMP,
		S_DNRD1,
		S_DNRD2,
		S_DNCMP,
		S_TOPRD,
		S_DONE
	} state_t;

	// Signed greater-than on keys.
	function automatic logic key_gt(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
		return $signed(a) > $signed(b);
	endfunction

endpackage

// ===== rtl/core/ihq_if.sv =====
// Valid/ready channel carrying one payload item.
interface ihq_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ihq_heap_mem.sv =====
// Heap slot memory, one write and one registered read port.
module ihq_heap_mem #(
	parameter int unsigned AW = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  ihq_pkg::entry_t   wdata,
	input  logic [AW-1:0]     raddr,
	output ihq_pkg::entry_t   rdata
);
	ihq_pkg::entry_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/ihq_pos_mem.sv =====
// Label-to-slot map memory; a valid bit per label gives the absent reset.
module ihq_pos_mem #(
	parameter int unsigned AW = 6,
	parameter int unsigned DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0]    mem [2**AW];
	logic [2**AW-1:0] vld_q;
	logic [DW-1:0]    rd_q;
	logic             rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rv_q <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rv_q ? rd_q : '0;
endmodule

// ===== rtl/core/indexed_max_heap_queue_unit.sv =====
// Indexed binary max-heap queue: top level with the sift sequencer.
// A refused item goes from the map read and check straight to the top-slot read; an insert
// sifts up, and a remove reads the removed and the last slot, then sifts up and then down.
// One item at a time: the next item is taken only in or after the cycle its result appears.
// The sequencer holds in its last step while the output register still holds an untaken result.
// Reset clears the count, the map valid bits and all control; heap data is left.
module indexed_max_heap_queue_unit #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned LABELS   = 64
) (
	input  logic clk,
	input  logic arst_n,
	ihq_if.sink   req,
	ihq_if.source rsp
);
	localparam int unsigned PW = $clog2(CAPACITY + 1);
	localparam int unsigned HA = $clog2(CAPACITY + 1);
	localparam int unsigned LA = ihq_pkg::LABEL_W;

	ihq_pkg::state_t st_q, st_d;
	ihq_pkg::req_t   req_q;
	ihq_pkg::rsp_t   rsp_q;
	logic            rsp_vld_q;
	logic [PW-1:0]   cnt_q, pos_q, cpos_q;
	ihq_pkg::entry_t e_q, c1_q, gone_q;
	logic [1:0]      status_q;

	// memory ports
	logic            h_we, m_we;
	logic [HA-1:0]   h_wa, h_ra;
	ihq_pkg::entry_t h_wd, h_rd;
	logic [LA-1:0]   m_wa, m_ra;
	logic [PW-1:0]   m_wd, m_rd;

	ihq_heap_mem #(.AW(HA)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
	);
	ihq_pos_mem #(.AW(LA), .DW(PW)) u_pos (
		.clk(clk), .arst_n(arst_n), .we(m_we), .waddr(m_wa), .wdata(m_wd),
		.raddr(m_ra), .rdata(m_rd)
	);

	logic lbl_ok;
	assign lbl_ok = (32'(req_q.label) < 32'(LABELS));

	assign req.ready = (st_q == ihq_pkg::S_IDLE);
	assign rsp.valid = rsp_vld_q;
	assign rsp.payload = rsp_q;

	// Next-state and memory control
	logic [PW-1:0]   pos_d, cpos_d, cnt_d;
	ihq_pkg::entry_t e_d, c1_d, gone_d;
	logic [1:0]      status_d;
	logic            fin;
	logic [PW:0]     c_l, c_r;

	always_comb begin
		st_d = st_q; pos_d = pos_q; cpos_d = cpos_q; cnt_d = cnt_q;
		e_d = e_q; c1_d = c1_q; gone_d = gone_q; status_d = status_q;
		h_we = 1'b0; h_wa = '0; h_wd = e_q; h_ra = '0;
		m_we = 1'b0; m_wa = e_q.label[LA-1:0]; m_wd = pos_q; m_ra = req_q.label[LA-1:0];
		fin = 1'b0;
		c_l = {pos_q, 1'b0};
		c_r = {pos_q, 1'b1};
		case (st_q)
			ihq_pkg::S_IDLE: begin
				if (req.valid) begin
					st_d = ihq_pkg::S_MAPRD;
				end
			end
			ihq_pkg::S_MAPRD: begin
				m_ra = req_q.label[LA-1:0];
				st_d = ihq_pkg::S_CHECK;
				status_d = ihq_pkg::ST_OK;
				gone_d = '0;
			end
			ihq_pkg::S_CHECK: begin
				if (!lbl_ok) begin
					status_d = ihq_pkg::ST_ABSENT; st_d = ihq_pkg::S_TOPRD;
				end else if (req_q.command == ihq_pkg::CMD_INSERT) begin
					if (m_rd != '0) begin
						status_d = ihq_pkg::ST_PRESENT; st_d = ihq_pkg::S_TOPRD;
					end else if (32'(cnt_q) >= 32'(CAPACITY)) begin
						status_d = ihq_pkg::ST_FULL; st_d = ihq_pkg::S_TOPRD;
					end else begin
						e_d = '{value: req_q.value, label: req_q.label};
						cnt_d = cnt_q + PW'(1);
						pos_d = cnt_q + PW'(1);
						st_d = ihq_pkg::S_UPRD;
					end
				end else begin
					if (m_rd == '0 || m_rd > cnt_q) begin
						status_d = ihq_pkg::ST_ABSENT; st_d = ihq_pkg::S_TOPRD;
					end else begin
						pos_d = m_rd;
						h_ra = m_rd[HA-1:0];
						st_d = ihq_pkg::S_RDGONE;
					end
				end
			end
			ihq_pkg::S_RDGONE: begin
				gone_d = h_rd;
				// clear removed label
				m_we = 1'b1; m_wa = req_q.label[LA-1:0]; m_wd = '0;
				h_ra = cnt_q[HA-1:0];
				cnt_d = cnt_q - PW'(1);
				st_d = ihq_pkg::S_RDLAST;
			end
			ihq_pkg::S_RDLAST: begin
				e_d = h_rd;
				if (pos_q <= cnt_q) begin
					st_d = ihq_pkg::S_UPRD;
				end else begin
					st_d = ihq_pkg::S_TOPRD;
				end
			end
			ihq_pkg::S_UPRD: begin
				if (pos_q > PW'(1)) begin
					h_ra = HA'(pos_q >> 1);
					st_d = ihq_pkg::S_UPCMP;
				end else begin
					st_d = ihq_pkg::S_DNRD1;
				end
			end
			ihq_pkg::S_UPCMP: begin
				if (ihq_pkg::key_gt(e_q.value, h_rd.value)) begin
					h_we = 1'b1; h_wa = pos_q[HA-1:0]; h_wd = h_rd;
					m_we = 1'b1; m_wa = h_rd.label[LA-1:0]; m_wd = pos_q;
					pos_d = pos_q >> 1;
					st_d = ihq_pkg::S_UPRD;
				end else begin
					st_d = ihq_pkg::S_DNRD1;
				end
			end
			ihq_pkg::S_DNRD1: begin
				if (req_q.command == ihq_pkg::CMD_INSERT || c_l > {1'b0, cnt_q}) begin
					fin = 1'b1;
					st_d = ihq_pkg::S_TOPRD;
				end else begin
					h_ra = c_l[HA-1:0];
					st_d = ihq_pkg::S_DNRD2;
				end
			end
			ihq_pkg::S_DNRD2: begin
				c1_d = h_rd;
				cpos_d = c_l[PW-1:0];
				h_ra = c_r[HA-1:0];
				st_d = ihq_pkg::S_DNCMP;
			end
			ihq_pkg::S_DNCMP: begin
				cpos_d = cpos_q;
				c1_d = c1_q;
				if (c_r <= {1'b0, cnt_q} && ihq_pkg::key_gt(h_rd.value, c1_q.value)) begin
					cpos_d = c_r[PW-1:0];
					c1_d = h_rd;
				end
				if (ihq_pkg::key_gt(c1_d.value, e_q.value)) begin
					h_we = 1'b1; h_wa = pos_q[HA-1:0]; h_wd = c1_d;
					m_we = 1'b1; m_wa = c1_d.label[LA-1:0]; m_wd = pos_q;
					pos_d = cpos_d;
					st_d = ihq_pkg::S_DNRD1;
				end else begin
					fin = 1'b1;
					st_d = ihq_pkg::S_TOPRD;
				end
			end
			ihq_pkg::S_TOPRD: begin
				h_ra = HA'(1);
				st_d = ihq_pkg::S_DONE;
			end
			ihq_pkg::S_DONE: begin
				// keep the top slot on the read port while the result waits
				h_ra = HA'(1);
				if (!rsp_vld_q || rsp.ready) begin
					st_d = ihq_pkg::S_IDLE;
				end
			end
			default: st_d = ihq_pkg::S_IDLE;
		endcase
		// final placement of the sifted entry
		if (fin) begin
			h_we = 1'b1; h_wa = pos_q[HA-1:0]; h_wd = e_q;
			m_we = 1'b1; m_wa = e_q.label[LA-1:0]; m_wd = pos_q;
		end
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ihq_pkg::S_IDLE;
			cnt_q <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			if (st_q == ihq_pkg::S_DONE && (!rsp_vld_q || rsp.ready)) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.payload;
		end
		pos_q <= pos_d; cpos_q <= cpos_d; e_q <= e_d; c1_q <= c1_d;
		gone_q <= gone_d; status_q <= status_d;
		if (st_q == ihq_pkg::S_DONE && (!rsp_vld_q || rsp.ready)) begin
			rsp_q.status <= status_q;
			rsp_q.removed_value <= gone_q.value;
			rsp_q.removed_label <= gone_q.label;
			rsp_q.empty_res <= (cnt_q == '0);
			rsp_q.max_value <= (cnt_q == '0) ? '0 : h_rd.value;
			rsp_q.max_label <= (cnt_q == '0) ? '0 : h_rd.label;
		end
	end
endmodule

// ===== rtl/core/ihq_checker.sv =====
// Port-level checks for the heap queue, bound to the top level.
module ihq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input ihq_pkg::rsp_t out_payload
);
	// empty heap reports zero max
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.empty_res |-> out_payload.max_value == '0
		&& out_payload.max_label == '0) else $error("empty max nonzero");
	// failed steps remove nothing
	a_fail_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.status != ihq_pkg::ST_OK |->
		out_payload.removed_value == '0 && out_payload.removed_label == '0)
		else $error("failed step removed");
	// an accepted item is not followed by another accept next cycle
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready not dropped");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result changed while stalled");
endmodule

bind indexed_max_heap_queue_unit ihq_checker u_ihq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready), .out_payload(rsp.payload)
);

// ===== tb/sv/ihq_tb_pkg.sv =====
// Testbench types: one row of the directed stimulus table.
package ihq_tb_pkg;

	// One directed row: request plus optional typed-in expectation.
	typedef struct {
		ihq_pkg::req_t req;
		logic          has_rsp;
		ihq_pkg::rsp_t rsp;
	} dir_row_t;
endpackage

// ===== tb/sv/indexed_max_heap_queue_unit_tb.sv =====
// Self-checking testbench for the indexed max-heap queue unit.
module indexed_max_heap_queue_unit_tb;

	localparam int CAP = 64;
	localparam int NLAB = 64;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ihq_if #(.payload_t(ihq_pkg::req_t)) req ();
	ihq_if #(.payload_t(ihq_pkg::rsp_t)) rsp ();

	indexed_max_heap_queue_unit #(.CAPACITY(CAP), .LABELS(NLAB)) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always #6 clk = ~clk;

	// Shadow heap state.
	ihq_pkg::entry_t hp [1:CAP];
	int unsigned slot_of [NLAB];
	int unsigned n_entries;

	ihq_pkg::rsp_t pending_rsp [$];
	int err_cnt = 0;
	int item_cnt = 0;
	int rsp_cnt = 0;
	int st_seen [4];
	longint cyc = 0;
	int send_idle_pct = 6;
	int recv_idle_pct = 52;
	int hold_cycles = 0;

	function automatic void place(int unsigned p, ihq_pkg::entry_t e);
		hp[p] = e;
		slot_of[e.label] = p;
	endfunction

	function automatic int unsigned bubble_up(int unsigned p);
		ihq_pkg::entry_t e;
		e = hp[p];
		while (p > 1 && $signed(e.value) > $signed(hp[p/2].value)) begin
			place(p, hp[p/2]);
			p = p / 2;
		end
		place(p, e);
		return p;
	endfunction

	function automatic void bubble_down(int unsigned p);
		ihq_pkg::entry_t e;
		int unsigned c;
		e = hp[p];
		while (p * 2 <= n_entries) begin
			c = p * 2;
			if (c != n_entries && $signed(hp[c+1].value) > $signed(hp[c].value))
				c++;
			if (!($signed(hp[c].value) > $signed(e.value)))
				break;
			place(p, hp[c]);
			p = c;
		end
		place(p, e);
	endfunction

	// Apply one request to the shadow heap and return the expected response.
	function automatic ihq_pkg::rsp_t heap_apply(ihq_pkg::req_t r);
		ihq_pkg::rsp_t o;
		ihq_pkg::entry_t e, gone, last;
		int unsigned p;
		o = '0;
		o.status = ihq_pkg::ST_OK;
		if (r.command == ihq_pkg::CMD_INSERT) begin
			if (slot_of[r.label] != 0) o.status = ihq_pkg::ST_PRESENT;
			else if (n_entries >= CAP) o.status = ihq_pkg::ST_FULL;
			else begin
				e.value = r.value;
				e.label = r.label;
				n_entries++;
				place(n_entries, e);
				void'(bubble_up(n_entries));
			end
		end else begin
			p = slot_of[r.label];
			if (p == 0 || p > n_entries) o.status = ihq_pkg::ST_ABSENT;
			else begin
				gone = hp[p];
				last = hp[n_entries];
				o.removed_value = gone.value;
				o.removed_label = gone.label;
				slot_of[r.label] = 0;
				n_entries--;
				if (p <= n_entries) begin
					place(p, last);
					p = bubble_up(p);
					bubble_down(p);
				end
			end
		end
		if (n_entries > 0) begin
			o.max_value = hp[1].value;
			o.max_label = hp[1].label;
		end else
			o.empty_res = 1'b1;
		return o;
	endfunction

	function automatic ihq_pkg::req_t mk(logic cmd, int lab, logic [31:0] v);
		ihq_pkg::req_t r;
		r.command = cmd;
		r.label = lab[5:0];
		r.value = v;
		return r;
	endfunction

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: random stall, or a long hold-off when requested.
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else
			rsp.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Response checker.
	always @(posedge clk) begin
		ihq_pkg::rsp_t exp_r, got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.payload;
			rsp_cnt++;
			if (pending_rsp.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10) $display("unexpected result %p", got);
			end else begin
				exp_r = pending_rsp.pop_front();
				st_seen[exp_r.status]++;
				if (got !== exp_r) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: st %0d/%0d rv %h/%h rl %0d/%0d mv %h/%h ml %0d/%0d e %b/%b",
							exp_r.status, got.status, exp_r.removed_value, got.removed_value,
							exp_r.removed_label, got.removed_label, exp_r.max_value,
							got.max_value, exp_r.max_label, got.max_label,
							exp_r.empty_res, got.empty_res);
				end
			end
		end
	end

	// Offer one item and wait until it is taken; queues the expected response.
	task automatic send_item(ihq_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_rsp = {pending_rsp, heap_apply(r)};
		item_cnt++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// Random item: mostly useful inserts/removes, some errors.
	function automatic ihq_pkg::req_t rand_item(int fill_bias);
		int lab;
		logic [31:0] v;
		int k;
		k = $urandom_range(99);
		case ($urandom_range(3))
			0: v = $urandom_range(15);
			1: v = {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_fff0} | $urandom_range(15);
			default: v = $urandom;
		endcase
		lab = $urandom_range(NLAB - 1);
		if (k < fill_bias) return mk(ihq_pkg::CMD_INSERT, lab, v);
		if (k < 95 && n_entries > 0)
			return mk(ihq_pkg::CMD_REMOVE, hp[$urandom_range(n_entries, 1)].label, v);
		return mk(1'($urandom_range(1)), lab, v);
	endfunction

	ihq_tb_pkg::dir_row_t dir_tab [$];

	task automatic add_row(ihq_pkg::req_t r, logic has, ihq_pkg::rsp_t o);
		ihq_tb_pkg::dir_row_t d;
		d.req = r;
		d.has_rsp = has;
		d.rsp = o;
		dir_tab = {dir_tab, d};
	endtask

	initial begin
		ihq_pkg::rsp_t z, o;
		ihq_pkg::req_t r;
		z = '0;
		req.valid = 1'b0;
		req.payload = '0;
		n_entries = 0;
		foreach (slot_of[i]) slot_of[i] = 0;

		// Directed rows; expected values typed in where obvious.
		o = z; o.status = ihq_pkg::ST_ABSENT; o.empty_res = 1;
		add_row(mk(ihq_pkg::CMD_REMOVE, 0, 0), 1, o);
		o = z; o.max_value = 32'h8000_0000; o.max_label = 6'd63;
		add_row(mk(ihq_pkg::CMD_INSERT, 63, 32'h8000_0000), 1, o);
		o = z; o.status = ihq_pkg::ST_PRESENT; o.max_value = 32'h8000_0000; o.max_label = 6'd63;
		add_row(mk(ihq_pkg::CMD_INSERT, 63, 32'h7fff_ffff), 1, o);
		o = z; o.max_value = 32'h7fff_ffff; o.max_label = 6'd0;
		add_row(mk(ihq_pkg::CMD_INSERT, 0, 32'h7fff_ffff), 1, o);
		add_row(mk(ihq_pkg::CMD_INSERT, 5, 32'h7fff_ffff), 0, z);
		add_row(mk(ihq_pkg::CMD_INSERT, 6, 32'hffff_ffff), 0, z);
		add_row(mk(ihq_pkg::CMD_INSERT, 7, 32'h0000_0000), 0, z);
		add_row(mk(ihq_pkg::CMD_REMOVE, 7, 0), 0, z);
		add_row(mk(ihq_pkg::CMD_REMOVE, 0, 0), 0, z);
		add_row(mk(ihq_pkg::CMD_REMOVE, 0, 0), 0, z);
		add_row(mk(ihq_pkg::CMD_REMOVE, 6, 32'hffff_ffff), 0, z);
		add_row(mk(ihq_pkg::CMD_REMOVE, 63, 0), 0, z);
		o = z; o.removed_value = 32'h7fff_ffff; o.removed_label = 6'd5; o.empty_res = 1;
		add_row(mk(ihq_pkg::CMD_REMOVE, 5, 0), 1, o);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].req);
			if (dir_tab[i].has_rsp && pending_rsp[$] !== dir_tab[i].rsp) begin
				err_cnt++;
				$display("directed row %0d: table disagrees with prediction", i);
			end
		end
		drain();

		// Fill to capacity, re-insert a present label, empty it, then a long receiver hold-off.
		for (int i = 0; i < CAP; i++) send_item(mk(ihq_pkg::CMD_INSERT, i, $urandom));
		send_item(mk(ihq_pkg::CMD_INSERT, 3, 0));
		for (int i = 0; i < CAP; i++) send_item(mk(ihq_pkg::CMD_REMOVE, i, 0));
		drain();
		hold_cycles = 400;
		for (int i = 0; i < 12; i++) send_item(rand_item(70));
		drain();

		// Random phases with three idle profiles.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 52 : 0;
			recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 6 : 0;
			for (int i = 0; i < 560; i++)
				send_item(rand_item((i % 200) < 100 ? 70 : 30));
			drain();
		end

		repeat (60) @(posedge clk);
		$display("%0d items sent, %0d results; status ok/full/absent/present = %0d/%0d/%0d/%0d",
			item_cnt, rsp_cnt, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
		if (err_cnt == 0 && pending_rsp.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/ihq_pkg.sv
rtl/core/ihq_if.sv
rtl/core/ihq_heap_mem.sv
rtl/core/ihq_pos_mem.sv
rtl/core/indexed_max_heap_queue_unit.sv
rtl/core/ihq_checker.sv
tb/sv/ihq_tb_pkg.sv
tb/sv/indexed_max_heap_queue_unit_tb.sv
